/* hdl/hse_pkg.sv */
package hse_pkg;

  // store geometry
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int VALUE_W    = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int IW         = AW + 2;

  // one input item
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } item_t;

  // one result item
  typedef struct packed {
    logic signed [VALUE_W-1:0] value_res;
    logic                      last_res;
    logic                      overflow;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic build_rd;
    logic build_x;
    logic sift_rd;
    logic sift_cmp;
    logic ext_rd;
    logic ext_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic half_zero;
    logic bidx_zero;
    logic no_child;
    logic move_down;
    logic size_one;
  } status_t;

endpackage

/* hdl/hse_datapath.sv */
module hse_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  hse_pkg::item_t   item,
  input  hse_pkg::cmd_t    cmd,
  output hse_pkg::status_t status,
  output hse_pkg::result_t result,
  output logic             strobe
);

  typedef logic signed [hse_pkg::DATA_WIDTH-1:0] data_t;

  // element store: one write port, two registered read ports
  data_t mem [hse_pkg::DEPTH];
  data_t rd0;
  data_t rd1;

  logic                    order_mode;
  logic [hse_pkg::CW-1:0]  cnt;
  logic                    ovf;
  logic [hse_pkg::CW-1:0]  size;
  logic [hse_pkg::CW-1:0]  bidx;
  logic [hse_pkg::AW-1:0]  root;
  data_t                   x;

  logic [hse_pkg::CW-1:0]  bidx_dec;
  logic [hse_pkg::CW-1:0]  size_dec;
  logic [hse_pkg::IW-1:0]  lidx;
  logic [hse_pkg::IW-1:0]  ridx;
  logic                    r_ok;
  logic                    pick_r;
  data_t                   child;
  logic [hse_pkg::IW-1:0]  cidx;
  logic                    not_full;

  logic                    we;
  logic [hse_pkg::AW-1:0]  waddr;
  data_t                   wdata;
  logic [hse_pkg::AW-1:0]  ra0;
  logic [hse_pkg::AW-1:0]  ra1;

  // a sits above b in the heap: min-heap for ascending output, max-heap for descending
  function automatic logic above(input data_t a, input data_t b, input logic mode);
    above = mode ? (a > b) : (a < b);
  endfunction

  assign bidx_dec = bidx - hse_pkg::CW'(1);
  assign size_dec = size - hse_pkg::CW'(1);
  assign lidx     = hse_pkg::IW'({root, 1'b1});
  assign ridx     = lidx + hse_pkg::IW'(1);
  assign r_ok     = ridx < hse_pkg::IW'(size);
  assign pick_r   = r_ok && above(rd1, rd0, order_mode);
  assign child    = pick_r ? rd1 : rd0;
  assign cidx     = pick_r ? ridx : lidx;
  assign not_full = cnt < hse_pkg::CW'(hse_pkg::DEPTH);

  assign status.half_zero = (cnt >> 1) == '0;
  assign status.bidx_zero = bidx == '0;
  assign status.no_child  = lidx >= hse_pkg::IW'(size);
  assign status.move_down = above(child, x, order_mode);
  assign status.size_one  = size == hse_pkg::CW'(1);

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = root;
    wdata = x;
    if (cmd.load) begin
      we    = not_full;
      waddr = cnt[hse_pkg::AW-1:0];
      wdata = item.value[hse_pkg::DATA_WIDTH-1:0];
    end else if (cmd.sift_rd) begin
      we = status.no_child;
    end else if (cmd.sift_cmp) begin
      we = 1'b1;
      if (status.move_down) begin
        wdata = child;
      end
    end
  end

  // read address select
  always_comb begin
    ra0 = '0;
    ra1 = '0;
    if (cmd.build_rd) begin
      ra0 = bidx_dec[hse_pkg::AW-1:0];
    end else if (cmd.sift_rd) begin
      ra0 = lidx[hse_pkg::AW-1:0];
      ra1 = ridx[hse_pkg::AW-1:0];
    end else if (cmd.ext_rd) begin
      ra1 = size_dec[hse_pkg::AW-1:0];
    end
  end

  // store access
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  // control registers: mode, fill count, overflow, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
      cnt        <= '0;
      ovf        <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= cmd.ext_out;
      if (cfg_wr_en) begin
        order_mode <= cfg_wr_data;
      end
      if (cmd.load) begin
        if (not_full) begin
          cnt <= cnt + hse_pkg::CW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end else if (cmd.ext_out && status.size_one) begin
        cnt <= '0;
        ovf <= 1'b0;
      end
    end
  end

  // sort working registers
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      size <= cnt;
      bidx <= cnt >> 1;
    end
    if (cmd.build_rd) begin
      root <= bidx_dec[hse_pkg::AW-1:0];
      bidx <= bidx_dec;
    end
    if (cmd.build_x) begin
      x <= rd0;
    end
    if (cmd.sift_cmp && status.move_down) begin
      root <= cidx[hse_pkg::AW-1:0];
    end
    if (cmd.ext_out) begin
      x    <= rd1;
      root <= '0;
      size <= size_dec;
    end
  end

  // result register: heap top goes out
  always_ff @(posedge clk) begin
    if (cmd.ext_out) begin
      result.value_res <= hse_pkg::VALUE_W'(rd0);
      result.last_res  <= status.size_one;
      result.overflow  <= ovf;
    end
  end

endmodule

/* hdl/hse_ctrl.sv */
module hse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             last,
  input  hse_pkg::status_t status,
  output hse_pkg::cmd_t    cmd,
  output logic             busy
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SETUP    = 8'b0000_0010,
    S_BUILD_RD = 8'b0000_0100,
    S_BUILD_X  = 8'b0000_1000,
    S_SIFT_RD  = 8'b0001_0000,
    S_SIFT_CMP = 8'b0010_0000,
    S_EXT_RD   = 8'b0100_0000,
    S_EXT_OUT  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  state_t after_sift;
  logic   building;
  logic   building_next;

  assign busy = state != S_IDLE;

  // commands follow the state
  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && start;
    cmd.setup    = state == S_SETUP;
    cmd.build_rd = state == S_BUILD_RD;
    cmd.build_x  = state == S_BUILD_X;
    cmd.sift_rd  = state == S_SIFT_RD;
    cmd.sift_cmp = state == S_SIFT_CMP;
    cmd.ext_rd   = state == S_EXT_RD;
    cmd.ext_out  = state == S_EXT_OUT;
  end

  // where a finished sift goes: next build root or next extraction
  assign after_sift = (building && !status.bidx_zero) ? S_BUILD_RD : S_EXT_RD;

  always_comb begin
    state_next    = state;
    building_next = building;
    case (state)
      S_IDLE: begin
        if (start && last) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        building_next = !status.half_zero;
        state_next    = status.half_zero ? S_EXT_RD : S_BUILD_RD;
      end
      S_BUILD_RD: state_next = S_BUILD_X;
      S_BUILD_X:  state_next = S_SIFT_RD;
      S_SIFT_RD: begin
        if (status.no_child) begin
          state_next = after_sift;
          if (status.bidx_zero) begin
            building_next = 1'b0;
          end
        end else begin
          state_next = S_SIFT_CMP;
        end
      end
      S_SIFT_CMP: begin
        if (status.move_down) begin
          state_next = S_SIFT_RD;
        end else begin
          state_next = after_sift;
          if (status.bidx_zero) begin
            building_next = 1'b0;
          end
        end
      end
      S_EXT_RD:  state_next = S_EXT_OUT;
      S_EXT_OUT: state_next = status.size_one ? S_IDLE : S_SIFT_RD;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      building <= 1'b0;
    end else begin
      state    <= state_next;
      building <= building_next;
    end
  end

endmodule

/* hdl/heap_sort_engine.sv */
// Loading: one item per cycle; busy stays low until an item marked last is accepted.
// Sorting: a setup state, a heap build, then one extraction per element. Each level a
// sift moves reads both children, then compares and writes. Results never go out back
// to back; the receiver cannot stall. Synchronous reset clears the controller, count,
// overflow flag, result strobe and order_mode.
module heap_sort_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  hse_pkg::item_t    item,
  output logic              strobe,
  output hse_pkg::result_t  result,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);

  hse_pkg::cmd_t    cmd;
  hse_pkg::status_t status;

  hse_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .last   (item.last),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  hse_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .cmd         (cmd),
    .status      (status),
    .result      (result),
    .strobe      (strobe)
  );

endmodule

/* hdl/hse_checker.sv */
module hse_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input hse_pkg::item_t   item,
  input logic             strobe,
  input hse_pkg::result_t result
);

  // two results never leave in consecutive cycles
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("result strobes in consecutive cycles");

  // only the final result of a run may show while the block is idle
  a_mid_run_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_res |-> busy)
    else $error("non-final result while idle");

  // an item without last keeps the block loading
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !item.last |=> !busy)
    else $error("busy after a non-final transfer");

  // an item with last starts the sort
  a_last_starts_sort: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.last |=> busy)
    else $error("sort did not start after final transfer");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .strobe (strobe),
  .result (result)
);
